// File: design/assert_macros.svh
// Assertion macros for the numeric literal classifier RTL.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, held off while reset is asserted.
`define NLC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked implication: the consequent is checked in the cycle after the antecedent.
`define NLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/nlc_pkg.sv
// Types and constants of the numeric literal classifier.
// Depends on nothing; used by every module of the block.
package nlc_pkg;

  typedef enum logic [2:0] {
    MODE_INIT   = 3'd0,
    MODE_ZERO   = 3'd1,
    MODE_EXP    = 3'd2,
    MODE_DEC    = 3'd3,
    MODE_HEX    = 3'd4,
    MODE_OCT    = 3'd5,
    MODE_LEGACY = 3'd6,
    MODE_BIN    = 3'd7
  } mode_t;

  localparam logic [3:0] KIND_NONE    = 4'd0;
  localparam logic [3:0] KIND_DEC     = 4'd1;
  localparam logic [3:0] KIND_HEX     = 4'd3;
  localparam logic [3:0] KIND_LEGACY  = 4'd5;
  localparam logic [3:0] KIND_OCT     = 4'd6;
  localparam logic [3:0] KIND_BIN     = 4'd8;
  localparam logic [3:0] KIND_MAX     = 4'd9;

  localparam logic [7:0] CH_E_LOWER   = 8'h65;
  localparam logic [7:0] CH_N_LOWER   = 8'h6E;
  localparam logic [7:0] CH_UNDERSC   = 8'h5F;
  localparam logic [7:0] CH_DOT       = 8'h2E;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_PLUS      = 8'h2B;
  localparam logic [7:0] CH_MINUS     = 8'h2D;

  localparam logic [3:0] DIGIT_ONE    = 4'd1;
  localparam logic [3:0] DIGIT_SEVEN  = 4'd7;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] literal_kind;
  } out_item_t;

  typedef struct packed {
    mode_t mode;
    logic  seen_dot;
    logic  seen_exponent;
    logic  big_suffix;
    logic  rejected;
    logic  prev_was_dot;
    logic  prev_was_underscore;
    logic  sign_may_follow;
    logic  prev_was_prefix;
  } nlc_state_t;

  localparam nlc_state_t STATE_RESET = '{
    mode: MODE_INIT, seen_dot: 1'b0, seen_exponent: 1'b0, big_suffix: 1'b0,
    rejected: 1'b0, prev_was_dot: 1'b0, prev_was_underscore: 1'b0,
    sign_may_follow: 1'b0, prev_was_prefix: 1'b0
  };

endpackage

// File: design/numeric_literal_classifier_core.sv
// Numeric literal classifier: takes one character of a candidate token per beat, up to one
// beat per cycle, and gives one verdict beat (accepted, literal kind) on the result port once the
// token's final character, held in the input register, is stepped into the result register.
// Characters pass through the input register into a combinational recognizer step that updates
// the parser state register; the verdict lands in the result register. The input is stalled only
// while the result register is full and stalled and the buffered character is a final one; other
// characters keep flowing. Depends on nlc_pkg, nlc_in_stage, nlc_step and assert_macros.svh.
`include "assert_macros.svh"

module numeric_literal_classifier_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  nlc_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output nlc_pkg::out_item_t out_data
);

  logic                q_valid;
  nlc_pkg::in_item_t   q_data;
  logic                advance;
  nlc_pkg::nlc_state_t state_r;
  nlc_pkg::nlc_state_t state_nxt;
  nlc_pkg::out_item_t  step_result;
  logic                out_valid_r;
  logic                out_valid_nxt;
  nlc_pkg::out_item_t  out_data_r;
  logic                verdict_ok;
  logic                kind_ok;
  logic                final_blocked;
  logic                final_taken;

  nlc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .in_stall (in_stall),
    .advance  (advance),
    .q_valid  (q_valid),
    .q_data   (q_data)
  );

  nlc_step u_step (
    .cur    (state_r),
    .item   (q_data),
    .nxt    (state_nxt),
    .result (step_result)
  );

  // A final character needs room in the result register; others never wait.
  assign advance = q_valid && (!q_data.last_char || !out_valid_r || !out_stall);

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (advance && q_data.last_char) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nlc_pkg::STATE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        state_r <= q_data.last_char ? nlc_pkg::STATE_RESET : state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && q_data.last_char) begin
      out_data_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign verdict_ok    = out_data_r.accepted == (out_data_r.literal_kind != nlc_pkg::KIND_NONE);
  assign kind_ok       = out_data_r.literal_kind <= nlc_pkg::KIND_MAX;
  assign final_blocked = out_valid_r && out_stall && q_data.last_char;
  assign final_taken   = advance && q_data.last_char;

  `NLC_ASSERT(a_verdict_consistent, !out_valid_r || verdict_ok, "accepted disagrees with kind")
  `NLC_ASSERT(a_kind_in_range, !out_valid_r || kind_ok, "literal kind out of range")
  `NLC_ASSERT(a_stall_cause, !in_stall || final_blocked, "input stalled without a final beat")
  `NLC_ASSERT_NEXT(a_token_restart, final_taken, state_r == nlc_pkg::STATE_RESET, "state kept")

endmodule

// File: design/nlc_in_stage.sv
// Input register of the classifier: holds one beat until the step logic takes it.
// Depends on nlc_pkg.
module nlc_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  nlc_pkg::in_item_t in_data,
  output logic              in_stall,
  input  logic              advance,
  output logic              q_valid,
  output nlc_pkg::in_item_t q_data
);

  logic              valid_r;
  nlc_pkg::in_item_t data_r;

  // The register is free when empty or when its beat moves on this cycle.
  assign in_stall = valid_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      data_r <= in_data;
    end
  end

  assign q_valid = valid_r;
  assign q_data  = data_r;

endmodule

// File: design/nlc_step.sv
// Per-character recognizer step: next parser state and the token verdict.
// Depends on nlc_pkg; purely combinational.
module nlc_step (
  input  nlc_pkg::nlc_state_t cur,
  input  nlc_pkg::in_item_t   item,
  output nlc_pkg::nlc_state_t nxt,
  output nlc_pkg::out_item_t  result
);

  logic [7:0] c;
  logic       last;
  logic [7:0] diff;
  logic [3:0] d;
  logic       is_digit;
  logic [3:0] kind;

  assign c        = item.char_code;
  assign last     = item.last_char;
  assign diff     = c - nlc_pkg::CH_ZERO;
  assign d        = diff[3:0];
  assign is_digit = (c >= nlc_pkg::CH_ZERO) && (c <= nlc_pkg::CH_NINE);

  always_comb begin
    nxt                     = cur;
    nxt.sign_may_follow     = 1'b0;
    nxt.prev_was_dot        = 1'b0;
    nxt.prev_was_underscore = 1'b0;
    nxt.prev_was_prefix     = 1'b0;
    if (!cur.rejected) begin
      if (cur.sign_may_follow && (c == nlc_pkg::CH_PLUS || c == nlc_pkg::CH_MINUS)) begin
        // A sign after the exponent needs at least one more character.
        if (last) begin
          nxt.rejected = 1'b1;
        end
      end else if (is_digit) begin
        if (cur.mode == nlc_pkg::MODE_HEX) begin
          nxt.mode = cur.mode;
        end else if (d == 4'd0 && cur.mode == nlc_pkg::MODE_INIT) begin
          nxt.mode = nlc_pkg::MODE_ZERO;
        end else if (d <= nlc_pkg::DIGIT_ONE && cur.mode == nlc_pkg::MODE_BIN) begin
          nxt.mode = cur.mode;
        end else if (d <= nlc_pkg::DIGIT_SEVEN &&
                     (cur.mode == nlc_pkg::MODE_OCT || cur.mode == nlc_pkg::MODE_LEGACY)) begin
          nxt.mode = cur.mode;
        end else if (d <= nlc_pkg::DIGIT_SEVEN && cur.mode == nlc_pkg::MODE_ZERO) begin
          nxt.mode = nlc_pkg::MODE_LEGACY;
        end else if (cur.mode == nlc_pkg::MODE_INIT || cur.mode == nlc_pkg::MODE_ZERO ||
                     cur.mode == nlc_pkg::MODE_LEGACY || cur.mode == nlc_pkg::MODE_DEC ||
                     cur.mode == nlc_pkg::MODE_EXP) begin
          nxt.mode = nlc_pkg::MODE_DEC;
        end else begin
          nxt.rejected = 1'b1;
        end
      end else begin
        case (c)
          "a", "A", "c", "C", "d", "D", "f", "F": begin
            if (cur.mode != nlc_pkg::MODE_HEX) begin
              nxt.rejected = 1'b1;
            end
          end
          "b", "B": begin
            if (cur.mode == nlc_pkg::MODE_ZERO) begin
              if (last) begin
                nxt.rejected = 1'b1;
              end else begin
                nxt.mode            = nlc_pkg::MODE_BIN;
                nxt.prev_was_prefix = 1'b1;
              end
            end else if (cur.mode != nlc_pkg::MODE_HEX) begin
              nxt.rejected = 1'b1;
            end
          end
          nlc_pkg::CH_E_LOWER, "E": begin
            if (cur.mode == nlc_pkg::MODE_DEC) begin
              if (cur.seen_exponent) begin
                nxt.rejected = 1'b1;
              end else begin
                nxt.seen_exponent   = 1'b1;
                nxt.sign_may_follow = 1'b1;
                nxt.mode            = nlc_pkg::MODE_EXP;
              end
            end else if (cur.mode != nlc_pkg::MODE_HEX) begin
              nxt.rejected = 1'b1;
            end
          end
          "x", "X": begin
            if (cur.mode != nlc_pkg::MODE_ZERO || last) begin
              nxt.rejected = 1'b1;
            end else begin
              nxt.mode            = nlc_pkg::MODE_HEX;
              nxt.prev_was_prefix = 1'b1;
            end
          end
          "o", "O": begin
            if (cur.mode != nlc_pkg::MODE_ZERO || last) begin
              nxt.rejected = 1'b1;
            end else begin
              nxt.mode            = nlc_pkg::MODE_OCT;
              nxt.prev_was_prefix = 1'b1;
            end
          end
          nlc_pkg::CH_UNDERSC: begin
            if (cur.mode == nlc_pkg::MODE_INIT || cur.mode == nlc_pkg::MODE_ZERO ||
                cur.prev_was_dot || cur.prev_was_prefix) begin
              nxt.rejected = 1'b1;
            end else begin
              nxt.prev_was_underscore = 1'b1;
            end
          end
          nlc_pkg::CH_N_LOWER: begin
            if (cur.mode == nlc_pkg::MODE_LEGACY || cur.prev_was_prefix || !last) begin
              nxt.rejected = 1'b1;
            end else begin
              nxt.big_suffix = 1'b1;
            end
          end
          nlc_pkg::CH_DOT: begin
            if (cur.seen_dot || cur.prev_was_underscore || cur.seen_exponent) begin
              nxt.rejected = 1'b1;
            end else begin
              nxt.seen_dot     = 1'b1;
              nxt.prev_was_dot = 1'b1;
              if (cur.mode == nlc_pkg::MODE_INIT || cur.mode == nlc_pkg::MODE_ZERO) begin
                nxt.mode = nlc_pkg::MODE_DEC;
              end else if (cur.mode != nlc_pkg::MODE_DEC) begin
                nxt.rejected = 1'b1;
              end
            end
          end
          default: begin
            nxt.rejected = 1'b1;
          end
        endcase
      end
    end
  end

  // Verdict on the state after this character; only used on the final beat.
  always_comb begin
    kind = nlc_pkg::KIND_NONE;
    if (!nxt.rejected) begin
      case (nxt.mode)
        nlc_pkg::MODE_ZERO,
        nlc_pkg::MODE_DEC:    kind = nlc_pkg::KIND_DEC + {3'd0, nxt.big_suffix};
        nlc_pkg::MODE_HEX:    kind = nlc_pkg::KIND_HEX + {3'd0, nxt.big_suffix};
        nlc_pkg::MODE_LEGACY: kind = nlc_pkg::KIND_LEGACY;
        nlc_pkg::MODE_OCT:    kind = nlc_pkg::KIND_OCT + {3'd0, nxt.big_suffix};
        nlc_pkg::MODE_BIN:    kind = nlc_pkg::KIND_BIN + {3'd0, nxt.big_suffix};
        default:              kind = nlc_pkg::KIND_NONE;
      endcase
    end
  end

  assign result.accepted     = (kind != nlc_pkg::KIND_NONE);
  assign result.literal_kind = kind;

endmodule
